@@ rtl/mes_pkg.sv @@
// Shared types and constants for the Mandelbrot escape shading block.
// No dependencies; used by the interfaces and every RTL module.
package mes_pkg;

	// Fixed field widths
	localparam int COORD_W    = 32;
	localparam int SHADE_W    = 17;
	localparam int STEP_W     = 16;
	localparam int SOFT_W     = 8;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOFTNESS = 1'b1;

	// Reset values
	localparam logic [CFG_DATA_W-1:0] MAX_ITER_RESET = 16'd500;
	localparam logic [SOFT_W-1:0]     SOFTNESS_RESET = 8'd50;

	// Shade scale: 1.0 and the number of quotient bits
	localparam logic [SHADE_W-1:0] SHADE_ONE = 17'h10000;
	localparam int QUO_BITS  = 16;
	localparam int QUO_CNT_W = $clog2(QUO_BITS + 1);

	// Controller <-> iteration datapath
	typedef struct packed {
		logic load;  // capture c, clear z and step counter
		logic step;  // commit z = z*z + c
	} iter_cmd_t;

	typedef struct packed {
		logic escaped;   // current z (after at least one step) is outside radius 2
		logic at_limit;  // step counter has reached max_iterations
	} iter_stat_t;

	// Controller <-> shade divider
	typedef struct packed {
		logic start;    // begin shade computation
		logic escaped;  // point escaped (else inside)
		logic publish;  // move result into output register
	} div_cmd_t;

	typedef struct packed {
		logic busy;
	} div_stat_t;

endpackage

@@ rtl/mes_if.sv @@
// Request channel interfaces: the point request and the shade result request.
// Depends on mes_pkg for field widths.
interface mes_point_if;
	logic                                valid;
	logic                                ready;
	logic signed [mes_pkg::COORD_W-1:0]  point_real;
	logic signed [mes_pkg::COORD_W-1:0]  point_imag;

	modport source (output valid, point_real, point_imag, input ready);
	modport sink   (input valid, point_real, point_imag, output ready);
endinterface

interface mes_result_if;
	logic                         valid;
	logic                         ready;
	logic [mes_pkg::SHADE_W-1:0]  shade;
	logic                         escaped;
	logic [mes_pkg::STEP_W-1:0]   step_count;

	modport source (output valid, shade, escaped, step_count, input ready);
	modport sink   (input valid, shade, escaped, step_count, output ready);
endinterface

@@ rtl/mandelbrot_escape_shade_unit.sv @@
// Mandelbrot escape-time shading unit, top level.
// Holds the configuration registers and joins controller, iteration datapath
// and shade divider. Depends on mes_pkg, mes_if, mes_ctrl, mes_iter, mes_div.
//
// point  : request channel with c (point_real, point_imag), signed with
//          COORD_FRAC_BITS fraction bits; taken when valid && ready.
// result : request channel with shade (65536 = 1.0), escaped and step_count;
//          held stable until ready.
// cfg_*  : plain write port; index 0 = max_iterations, 1 = escape_softness.
//          Write only while no point is in flight.
// Timing: one point at a time; each evaluation of z passes the MUL, SUM and
//   EVAL states (partial products, product sum, escape test / update); a
//   point that runs n steps needs n+1 evaluations. Result valid rises after
//   the last one and after the bit-serial divider when it runs (escape with nonzero
//   softness). Inside points have n = max_iterations, a point escaping at step
//   i has n = i+1. Ready rises again in the cycle after the result is handed off.
// Output stall: the result waits in an output register while the next point
//   is accepted and iterated; only its hand-off waits for the register.
// Reset: asynchronous, active low; idle, result valid low, max_iterations = 500,
//   escape_softness = 50.
module mandelbrot_escape_shade_unit #(
	parameter int COORD_FRAC_BITS = 28,
	parameter int COUNT_WIDTH     = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [mes_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mes_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
	mes_point_if.sink                         point,
	mes_result_if.source                      result
);

	// configuration registers
	logic [COUNT_WIDTH-1:0]         max_iter_q;
	logic [mes_pkg::SOFT_W-1:0]     softness_q;

	// command / status between controller and datapath parts
	mes_pkg::iter_cmd_t   icmd;
	mes_pkg::iter_stat_t  istat;
	mes_pkg::div_cmd_t    dcmd;
	mes_pkg::div_stat_t   dstat;
	logic [COUNT_WIDTH-1:0] result_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= COUNT_WIDTH'(mes_pkg::MAX_ITER_RESET);
			softness_q <= mes_pkg::SOFTNESS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				mes_pkg::CFG_MAX_ITER: max_iter_q <= COUNT_WIDTH'(cfg_wr_data);
				mes_pkg::CFG_SOFTNESS: softness_q <= cfg_wr_data[mes_pkg::SOFT_W-1:0];
				default: ;
			endcase
		end
	end

	mes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (point.valid),
		.in_ready  (point.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.istat     (istat),
		.icmd      (icmd),
		.dstat     (dstat),
		.dcmd      (dcmd)
	);

	// z = z*z + c loop and escape test
	mes_iter #(
		.COORD_FRAC_BITS (COORD_FRAC_BITS),
		.COUNT_WIDTH     (COUNT_WIDTH)
	) u_iter (
		.clk          (clk),
		.cmd          (icmd),
		.point_real   (point.point_real),
		.point_imag   (point.point_imag),
		.max_iter     (max_iter_q),
		.stat         (istat),
		.result_count (result_count)
	);

	// shade mapping i/(i+s) and output payload register
	mes_div #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dcmd),
		.count      (result_count),
		.softness   (softness_q),
		.stat       (dstat),
		.shade      (result.shade),
		.escaped    (result.escaped),
		.step_count (result.step_count)
	);

endmodule

@@ rtl/mes_iter.sv @@
// Iteration datapath: z = z*z + c with split partial-product multipliers and
// an exact escape test. Depends on mes_pkg.
module mes_iter #(
	parameter int COORD_FRAC_BITS = 28,
	parameter int COUNT_WIDTH     = 16
) (
	input  logic                              clk,
	input  mes_pkg::iter_cmd_t                cmd,
	input  logic signed [mes_pkg::COORD_W-1:0] point_real,
	input  logic signed [mes_pkg::COORD_W-1:0] point_imag,
	input  logic [COUNT_WIDTH-1:0]            max_iter,
	output mes_pkg::iter_stat_t               stat,
	output logic [COUNT_WIDTH-1:0]            result_count
);

	localparam int F     = COORD_FRAC_BITS;
	localparam int MAG_W = F + 2;                 // |z| <= 2 when multiplied
	localparam int HW    = (MAG_W + 1) / 2;       // multiplier half width
	localparam int OPW   = 2 * HW;
	localparam int PPW   = 2 * HW;
	localparam int PRW   = 4 * HW;
	localparam int CORE  = (F + 3 > 31) ? F + 3 : 31;
	localparam int ZW    = CORE + 2;              // holds 2*z.re*z.im + c

	localparam logic [ZW-1:0]  BOUND     = {{(ZW-1){1'b0}}, 1'b1} << (F + 1);
	localparam logic [PRW:0]   RAD_LIMIT = {{PRW{1'b0}}, 1'b1} << (2 * F + 2);

	logic signed [ZW-1:0]     c_re_q, c_im_q, z_re_q, z_im_q;
	logic [COUNT_WIDTH-1:0]   cnt_q;

	logic [ZW-1:0]   mag_re, mag_im;
	logic [OPW-1:0]  op_re, op_im;
	logic [HW-1:0]   re_lo, re_hi, im_lo, im_hi;

	logic [PPW-1:0]  rr_ll_s1, rr_lh_s1, rr_hh_s1;
	logic [PPW-1:0]  ii_ll_s1, ii_lh_s1, ii_hh_s1;
	logic [PPW-1:0]  ri_ll_s1, ri_lh_s1, ri_hl_s1, ri_hh_s1;
	logic            over_s1, neg_s1;

	logic [PRW-1:0]  sq_re_s2, sq_im_s2, cross_s2;
	logic            over_s2, neg_s2;

	logic [PRW:0]          rad_sum;
	logic                  esc;
	logic signed [ZW-1:0]  sr, si, cm, cx, z_re_nxt, z_im_nxt;

	// operand magnitudes; out-of-bound values are flagged and never used
	assign mag_re = z_re_q[ZW-1] ? -z_re_q : z_re_q;
	assign mag_im = z_im_q[ZW-1] ? -z_im_q : z_im_q;
	assign op_re  = OPW'(mag_re[MAG_W-1:0]);
	assign op_im  = OPW'(mag_im[MAG_W-1:0]);
	assign re_lo  = op_re[HW-1:0];
	assign re_hi  = op_re[OPW-1:HW];
	assign im_lo  = op_im[HW-1:0];
	assign im_hi  = op_im[OPW-1:HW];

	// stage 1: partial products
	always_ff @(posedge clk) begin
		rr_ll_s1 <= re_lo * re_lo;
		rr_lh_s1 <= re_lo * re_hi;
		rr_hh_s1 <= re_hi * re_hi;
		ii_ll_s1 <= im_lo * im_lo;
		ii_lh_s1 <= im_lo * im_hi;
		ii_hh_s1 <= im_hi * im_hi;
		ri_ll_s1 <= re_lo * im_lo;
		ri_lh_s1 <= re_lo * im_hi;
		ri_hl_s1 <= re_hi * im_lo;
		ri_hh_s1 <= re_hi * im_hi;
		over_s1  <= (mag_re > BOUND) || (mag_im > BOUND);
		neg_s1   <= z_re_q[ZW-1] ^ z_im_q[ZW-1];
	end

	// stage 2: full exact products
	always_ff @(posedge clk) begin
		sq_re_s2 <= (PRW'(rr_hh_s1) << (2 * HW)) + (PRW'(rr_lh_s1) << (HW + 1))
			+ PRW'(rr_ll_s1);
		sq_im_s2 <= (PRW'(ii_hh_s1) << (2 * HW)) + (PRW'(ii_lh_s1) << (HW + 1))
			+ PRW'(ii_ll_s1);
		cross_s2 <= (PRW'(ri_hh_s1) << (2 * HW)) + (PRW'(ri_lh_s1) << HW)
			+ (PRW'(ri_hl_s1) << HW) + PRW'(ri_ll_s1);
		over_s2  <= over_s1;
		neg_s2   <= neg_s1;
	end

	// escape test on exact squares, update with truncated products
	assign rad_sum  = (PRW+1)'(sq_re_s2) + (PRW+1)'(sq_im_s2);
	assign esc      = over_s2 || (rad_sum > RAD_LIMIT);
	assign sr       = signed'(ZW'(sq_re_s2 >> F));
	assign si       = signed'(ZW'(sq_im_s2 >> F));
	assign cm       = signed'(ZW'(cross_s2 >> F));
	assign cx       = neg_s2 ? -cm : cm;
	assign z_re_nxt = sr - si + c_re_q;
	assign z_im_nxt = (cx <<< 1) + c_im_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			c_re_q <= {{(ZW-mes_pkg::COORD_W){point_real[mes_pkg::COORD_W-1]}}, point_real};
			c_im_q <= {{(ZW-mes_pkg::COORD_W){point_imag[mes_pkg::COORD_W-1]}}, point_imag};
			z_re_q <= '0;
			z_im_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.step) begin
			z_re_q <= z_re_nxt;
			z_im_q <= z_im_nxt;
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	assign stat.escaped  = (cnt_q != '0) && esc;
	assign stat.at_limit = (cnt_q == max_iter);
	assign result_count  = stat.escaped ? cnt_q - 1'b1 : cnt_q;

endmodule

@@ rtl/mes_div.sv @@
// Shade unit: restoring divider for floor(65536*i/(i+s)) plus the output
// payload register. Depends on mes_pkg.
module mes_div #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mes_pkg::div_cmd_t             cmd,
	input  logic [COUNT_WIDTH-1:0]        count,
	input  logic [mes_pkg::SOFT_W-1:0]    softness,
	output mes_pkg::div_stat_t            stat,
	output logic [mes_pkg::SHADE_W-1:0]   shade,
	output logic                          escaped,
	output logic [mes_pkg::STEP_W-1:0]    step_count
);

	logic                               busy_q;
	logic [mes_pkg::QUO_CNT_W-1:0]      bits_q;
	logic [COUNT_WIDTH:0]               den_q, rem_q;
	logic [mes_pkg::QUO_BITS-1:0]       quo_q;
	logic                               long_q, esc_q;
	logic [mes_pkg::SHADE_W-1:0]        fixed_q;
	logic [COUNT_WIDTH-1:0]             cnt_q;

	logic [COUNT_WIDTH+1:0]  rem2;
	logic                    ge;
	logic                    start_long;

	assign rem2       = {rem_q, 1'b0};
	assign ge         = rem2 >= {1'b0, den_q};
	assign start_long = cmd.escaped && (softness != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bits_q <= '0;
		end else if (cmd.start) begin
			busy_q <= start_long;
			bits_q <= mes_pkg::QUO_CNT_W'(mes_pkg::QUO_BITS);
		end else if (busy_q) begin
			bits_q <= bits_q - 1'b1;
			if (bits_q == mes_pkg::QUO_CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			den_q   <= (COUNT_WIDTH+1)'(count) + (COUNT_WIDTH+1)'(softness);
			rem_q   <= (COUNT_WIDTH+1)'(count);  // i < i+s, so quotient fits 16 bits
			quo_q   <= '0;
			long_q  <= start_long;
			esc_q   <= cmd.escaped;
			cnt_q   <= count;
			// inside, or zero softness: no division
			fixed_q <= (cmd.escaped && (count == '0)) ? '0 : mes_pkg::SHADE_ONE;
		end else if (busy_q) begin
			rem_q <= ge ? (COUNT_WIDTH+1)'(rem2 - (COUNT_WIDTH+2)'(den_q))
				: (COUNT_WIDTH+1)'(rem2);
			quo_q <= {quo_q[mes_pkg::QUO_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			shade      <= long_q ? mes_pkg::SHADE_W'(quo_q) : fixed_q;
			escaped    <= esc_q;
			step_count <= mes_pkg::STEP_W'(cnt_q);
		end
	end

	assign stat.busy = busy_q;

endmodule

@@ rtl/mes_ctrl.sv @@
// Controller state machine: sequences load, multiply, sum, evaluate and
// shade phases, and owns both request handshakes. Depends on mes_pkg.
module mes_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  mes_pkg::iter_stat_t  istat,
	output mes_pkg::iter_cmd_t   icmd,
	input  mes_pkg::div_stat_t   dstat,
	output mes_pkg::div_cmd_t    dcmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_SUM   = 5'b00100,
		ST_EVAL  = 5'b01000,
		ST_SHADE = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   in_fire, slot_free, finish;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign finish    = istat.escaped || istat.at_limit;

	assign icmd.load    = in_fire;
	assign icmd.step    = (state_q == ST_EVAL) && !finish;
	assign dcmd.start   = (state_q == ST_EVAL) && finish;
	assign dcmd.escaped = istat.escaped;
	assign dcmd.publish = (state_q == ST_SHADE) && !dstat.busy && slot_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_fire) state_d = ST_MUL;
			ST_MUL:   state_d = ST_SUM;
			ST_SUM:   state_d = ST_EVAL;
			ST_EVAL:  state_d = finish ? ST_SHADE : ST_MUL;
			ST_SHADE: if (dcmd.publish) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dcmd.publish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_accept_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_MUL)
		else $error("accepted request did not start an iteration");

	a_step_xor_start: assert property (@(posedge clk) disable iff (!arst_n)
		!(icmd.step && dcmd.start))
		else $error("iteration step and shade start together");

	a_busy_in_shade: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.busy |-> state_q == ST_SHADE)
		else $error("divider busy outside shade phase");

	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.publish |=> out_valid_q)
		else $error("published result not presented");

endmodule

@@ tb/mes_shade_checker.sv @@
`timescale 1ns / 1ps
// Shade checker: watches the config port and both request channels, predicts
// each result from its own copy of the registers. Needs mes_pkg, mes_if.
module mes_shade_checker #(
	parameter int COORD_FRAC_BITS = 28
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [mes_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mes_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	mes_point_if                           point,
	mes_result_if                          result,
	output int                             error_count,
	output int                             pending,
	output int                             result_count,
	output int                             escape_count
);

	localparam logic [127:0] RADIUS_SQ = 128'd1 << (2 * COORD_FRAC_BITS + 2);

	typedef struct packed {
		logic [mes_pkg::SHADE_W-1:0] shade;
		logic                        escaped;
		logic [mes_pkg::STEP_W-1:0]  step_count;
	} shade_t;

	typedef struct {
		logic signed [mes_pkg::COORD_W-1:0] cr;
		logic signed [mes_pkg::COORD_W-1:0] ci;
		shade_t                             want;
	} shade_job_t;

	logic [mes_pkg::STEP_W-1:0] iter_limit;
	logic [mes_pkg::SOFT_W-1:0] softness;
	shade_job_t        shade_expect_q[$];
	shade_job_t        job;
	int                mismatches = 0;
	int                n_results  = 0;
	int                n_escaped  = 0;

	assign error_count  = mismatches;
	assign result_count = n_results;
	assign escape_count = n_escaped;

	function automatic logic [63:0] abs64(input logic signed [63:0] v);
		return v[63] ? -v : v;
	endfunction

	// exact product, truncated toward zero
	function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [127:0] p;
		logic [63:0]  m;
		p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
		m = p[COORD_FRAC_BITS +: 64];
		return (a[63] ^ b[63]) ? -$signed(m) : $signed(m);
	endfunction

	function automatic shade_t predict_shade(input logic signed [mes_pkg::COORD_W-1:0] re,
			input logic signed [mes_pkg::COORD_W-1:0] im,
			input logic [mes_pkg::STEP_W-1:0] limit,
			input logic [mes_pkg::SOFT_W-1:0] smooth);
		logic signed [63:0] cr, ci, zr, zi, sr, si, cx;
		logic [63:0]        ur, ui;
		logic [127:0]       mag2;
		longint unsigned    num, den;
		int unsigned        step;
		shade_t             r;
		cr = re;
		ci = im;
		zr = '0;
		zi = '0;
		r.shade      = mes_pkg::SHADE_ONE;
		r.escaped    = 1'b0;
		r.step_count = limit;
		for (step = 0; step < limit; step++) begin
			sr = fx_mul(zr, zr);
			si = fx_mul(zi, zi);
			cx = fx_mul(zr, zi);
			zr = sr - si + cr;
			zi = 2 * cx + ci;
			ur = abs64(zr);
			ui = abs64(zi);
			// strict |z| > 2; a big component lands here too
			mag2 = {64'd0, ur} * {64'd0, ur} + {64'd0, ui} * {64'd0, ui};
			if (mag2 > RADIUS_SQ) begin
				num          = longint'(step) << mes_pkg::QUO_BITS;
				den          = step + smooth;
				// zero softness with an escape at step zero gives shade 0
				r.shade      = (den == 0) ? '0 : mes_pkg::SHADE_W'(num / den);
				r.escaped    = 1'b1;
				r.step_count = mes_pkg::STEP_W'(step);
				return r;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_limit <= mes_pkg::MAX_ITER_RESET[mes_pkg::STEP_W-1:0];
			softness   <= mes_pkg::SOFTNESS_RESET;
			shade_expect_q.delete();
			pending    <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					mes_pkg::CFG_MAX_ITER: iter_limit <= cfg_wr_data[mes_pkg::STEP_W-1:0];
					mes_pkg::CFG_SOFTNESS: softness <= cfg_wr_data[mes_pkg::SOFT_W-1:0];
					default: ;
				endcase
			end
			// results first: a result taken this edge belongs to an older point
			if (result.valid && result.ready) begin
				n_results++;
				if (result.escaped)
					n_escaped++;
				if (shade_expect_q.size() == 0) begin
					report_mismatch($sformatf(
						"result with no point pending: shade %0d esc %0b step %0d",
						result.shade, result.escaped, result.step_count));
				end else begin
					job = shade_expect_q.pop_front();
					if (result.shade !== job.want.shade)
						report_mismatch($sformatf("c=(%0d,%0d) shade %0d, expected %0d",
							job.cr, job.ci, result.shade, job.want.shade));
					if (result.escaped !== job.want.escaped)
						report_mismatch($sformatf("c=(%0d,%0d) escaped %0b, expected %0b",
							job.cr, job.ci, result.escaped, job.want.escaped));
					if (result.step_count !== job.want.step_count)
						report_mismatch($sformatf("c=(%0d,%0d) step_count %0d, expected %0d",
							job.cr, job.ci, result.step_count, job.want.step_count));
				end
			end
			if (point.valid && point.ready) begin
				job.cr   = point.point_real;
				job.ci   = point.point_imag;
				job.want = predict_shade(point.point_real, point.point_imag,
					iter_limit, softness);
				shade_expect_q.insert(shade_expect_q.size(), job);
			end
			pending <= shade_expect_q.size();
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the Mandelbrot escape shading unit: drives points and config
// writes, randomizes flow control and gives the verdict. Needs mes_pkg, mes_if,
// mes_shade_checker.
module tb;

	// An inside point at a step limit of 65535 runs with no request moving; the
	// limit must outlast it.
	localparam int WATCHDOG_LIMIT = 800_000;
	localparam int TAIL_CYCLES    = 40;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 115;
	localparam int EXTREME_ITEMS  = 60;

	// Q3.28 coordinates
	localparam logic signed [mes_pkg::COORD_W-1:0] FX_ONE = 32'sh1000_0000;
	localparam logic signed [mes_pkg::COORD_W-1:0] FX_TWO = 32'sh2000_0000;
	localparam logic signed [mes_pkg::COORD_W-1:0] FX_MIN = 32'sh8000_0000;
	localparam logic signed [mes_pkg::COORD_W-1:0] FX_MAX = 32'sh7fff_ffff;
	localparam int unsigned NEAR_SPAN = 32'd671088640;   // 2.5 in Q3.28

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic                           clk         = 1'b0;
	logic                           arst_n      = 1'b0;
	logic                           cfg_wr_en   = 1'b0;
	logic [mes_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [mes_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;

	mes_point_if  point ();
	mes_result_if result ();

	int mismatches, outstanding, n_results, n_escaped;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int stall_cycles   = 0;
	int settings_run   = 0;

	always #5 clk = ~clk;

	mandelbrot_escape_shade_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.point       (point),
		.result      (result)
	);

	mes_shade_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wr_data  (cfg_wr_data),
		.point        (point),
		.result       (result),
		.error_count  (mismatches),
		.pending      (outstanding),
		.result_count (n_results),
		.escape_count (n_escaped)
	);

	// result side: per-cycle random backpressure
	always @(negedge clk) begin
		result.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// watchdog: cycles since any request moved on either channel
	always @(posedge clk) begin
		if ((point.valid && point.ready) || (result.valid && result.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no request moved for %0d cycles, %0d results pending",
			stall_cycles, outstanding);
		$display("FAIL");
		$finish;
	end

	function automatic logic [mes_pkg::COORD_W-1:0] to_fx(input real v);
		return mes_pkg::COORD_W'($rtoi(v * 268435456.0));
	endfunction

	function automatic logic [mes_pkg::COORD_W-1:0] boundary_coord();
		case ($urandom_range(0, 6))
			0: return FX_TWO;
			1: return -FX_TWO;
			2: return FX_TWO + 1;
			3: return -FX_TWO - 1;
			4: return '0;
			5: return FX_MIN;
			default: return FX_MAX;
		endcase
	endfunction

	// Mostly points around the set so step counts spread out; the rest is
	// raw noise, boundary components and the cusp at 0.25.
	function automatic void pick_point(output logic [mes_pkg::COORD_W-1:0] re,
			output logic [mes_pkg::COORD_W-1:0] im);
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			re = -FX_TWO + $urandom_range(0, NEAR_SPAN);
			im = $urandom_range(0, NEAR_SPAN) - NEAR_SPAN / 2;
		end else if (kind < 80) begin
			re = $urandom;
			im = $urandom;
		end else if (kind < 90) begin
			re = boundary_coord();
			im = boundary_coord();
		end else begin
			re = (FX_ONE >>> 2) + $urandom_range(0, 1 << 22) - (1 << 20);
			im = $urandom_range(0, 1 << 16) - (1 << 15);
		end
	endfunction

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_SENDER:   begin send_idle_pct = 68; recv_stall_pct = 0;  end
			IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 68; end
			IDLE_BOTH:     begin send_idle_pct = 22; recv_stall_pct = 22; end
			default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
		endcase
	endtask

	// Called at a falling edge; returns at the falling edge after the handshake
	// with valid still high, so the next call either idles or presents a new point.
	task automatic send_point(input logic [mes_pkg::COORD_W-1:0] re,
			input logic [mes_pkg::COORD_W-1:0] im);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			point.valid <= 1'b0;
			@(negedge clk);
		end
		point.valid      <= 1'b1;
		point.point_real <= re;
		point.point_imag <= im;
		do @(posedge clk); while (!point.ready);
		@(negedge clk);
	endtask

	task automatic send_xy(input real re, input real im);
		send_point(to_fx(re), to_fx(im));
	endtask

	// hold off new points until every pending result has been taken
	task automatic wait_drained();
		point.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [mes_pkg::CFG_IDX_W-1:0] idx,
			input logic [mes_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= data;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// registers change only with the unit idle
	task automatic apply_setting(input logic [mes_pkg::STEP_W-1:0] limit,
			input logic [mes_pkg::SOFT_W-1:0] smooth);
		wait_drained();
		write_reg(mes_pkg::CFG_MAX_ITER, limit);
		// upper byte is junk, the unit keeps only the low eight bits
		write_reg(mes_pkg::CFG_SOFTNESS, {8'($urandom_range(0, 255)), smooth});
		settings_run++;
	endtask

	initial begin
		logic [mes_pkg::COORD_W-1:0] re, im;
		int                          p, k;

		point.valid      = 1'b0;
		point.point_real = '0;
		point.point_imag = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed points at the reset registers (500 steps, softness 50).
		settings_run = 1;
		send_xy(0.0, 0.0);              // origin, bounded
		send_xy(2.0, 0.0);              // |z| exactly 2 is not out; escapes one step later
		send_xy(-2.0, 0.0);             // sits on |z| = 2 forever
		send_xy(0.0, 2.0);
		send_xy(0.0, -2.0);
		send_point(FX_TWO + 1, '0);     // just past 2: out at step zero, shade 0
		send_point(FX_MAX, FX_MAX);
		send_point(FX_MIN, FX_MIN);
		send_point(FX_MIN, FX_MAX);
		send_point(FX_MAX, FX_MIN);
		send_xy(-1.0, 0.0);             // period-two orbit
		send_xy(0.0, 1.0);
		send_xy(0.25, 0.0);             // cusp of the cardioid
		send_xy(0.26, 0.0);             // slow escape past the cusp
		send_xy(-0.75, 0.1);
		send_xy(1.0, 1.0);
		send_point('1, '1);             // one LSB below zero on both axes
		send_xy(-1.5, 0.0);
		send_xy(0.3, 0.5);
		send_point(-FX_TWO, '1);
		send_xy(4.0, 0.0);

		// Low extremes: one step, softness 1.
		apply_setting(16'd1, 8'd1);
		for (k = 0; k < EXTREME_ITEMS; k++) begin
			pick_point(re, im);
			send_point(re, im);
		end

		// High extremes: 65535 steps, softness 255. Only one bounded point here,
		// the rest escape, some only after hundreds of steps near the cusp.
		apply_setting(16'hffff, 8'd255);
		send_xy(0.0, 0.0);
		send_xy(0.26, 0.0);
		send_xy(-0.75, 0.1);
		for (k = 0; k < 8; k++) begin
			if (k[0]) begin
				re = $urandom_range(0, 1) ? (FX_TWO + 1 + $urandom_range(0, 3 * FX_TWO))
					: (-FX_TWO - 1 - $urandom_range(0, 3 * FX_TWO - 1));
				im = $urandom;
			end else begin
				re = (FX_ONE >>> 2) + $urandom_range(1 << 12, 1 << 24);
				im = $urandom_range(0, 1 << 10) - (1 << 9);
			end
			send_point(re, im);
		end

		// Random phases, cycling through the flow-control mixes; small step
		// limits keep the run short, one phase uses a mid-size limit.
		for (p = 0; p < RANDOM_PHASES; p++) begin
			apply_setting((p == 5) ? 16'd300 : 16'($urandom_range(1, 64)),
				8'($urandom_range(1, 255)));
			set_idling(idle_mode_t'(p % 4));
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 2 && k == PHASE_ITEMS / 2)
					wait_drained();
				pick_point(re, im);
				send_point(re, im);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("checked %0d points (%0d escaped, %0d bounded) over %0d register settings",
			n_results, n_escaped, n_results - n_escaped, settings_run);
		$display("step limits 1 to 65535, softness 1 to 255, all sender/receiver stall mixes");
		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
